// File: src/cdq_pkg.sv
// Shared constants and types for the circular deque engine.
`default_nettype none

package cdq_pkg;

  // Default number of slots in the ring buffer.
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // Fixed payload widths.
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;

  // Command codes carried by an input item.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_LIST_FWD   = 3'd4,
    CMD_LIST_BWD   = 3'd5
  } cmd_t;

  // Status codes carried by a result item.
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

endpackage

`default_nettype wire

// File: src/cdq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: src/circular_deque_engine.sv
// Top level of the circular deque engine: control, ring indices and result port.
//
//   channel  | ports                                         | direction
//   ---------+-----------------------------------------------+----------
//   input    | start, busy, in_cmd, in_item_value            | in (busy out)
//   result   | out_valid, out_value, out_status, out_is_last | out
//
// A push or pop gives a single result, which appears on the cycle after the
// command is taken. A listing of N stored values holds busy high while it reads
// the slot RAM once per cycle, and each result appears on the cycle after its
// read, one per cycle. Reset clears the front index, the count and the
// sequencer; the slot RAM is not cleared. The receiver cannot stall results.
`default_nettype none

module circular_deque_engine #(
  parameter int unsigned QUEUE_DEPTH = cdq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic        [cdq_pkg::CMD_W-1:0]    in_cmd,
  input  wire logic signed [cdq_pkg::VALUE_W-1:0]  in_item_value,
  output logic                                     out_valid,
  output logic signed      [cdq_pkg::VALUE_W-1:0]  out_value,
  output logic             [cdq_pkg::STATUS_W-1:0] out_status,
  output logic                                     out_is_last
);

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = IDX_W + 1;

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S   = SUM_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LIST = 2'b10
  } state_t;

  state_t                          state_r, state_nxt;
  logic [IDX_W-1:0]                front_r, front_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic [CNT_W-1:0]                list_idx_r, list_idx_nxt;
  logic                            list_bwd_r, list_bwd_nxt;
  logic                            stat_vld_r, stat_vld_nxt;
  logic [cdq_pkg::STATUS_W-1:0]    stat_code_r, stat_code_nxt;
  logic                            rd_pend_r, rd_pend_nxt;
  logic                            rd_last_r, rd_last_nxt;

  logic                            accept;
  logic                            is_full;
  logic                            is_empty;
  logic [CNT_W-1:0]                last_cnt;
  logic [CNT_W-1:0]                list_pos;
  logic [SUM_W-1:0]                list_sum;
  logic [IDX_W-1:0]                list_slot;
  logic [SUM_W-1:0]                back_sum;
  logic [IDX_W-1:0]                back_slot;
  logic [IDX_W-1:0]                front_dec;
  logic [IDX_W-1:0]                front_inc;
  logic                            list_last;
  logic                            wr_en;
  logic [IDX_W-1:0]                wr_addr;
  logic                            rd_en;
  logic [cdq_pkg::VALUE_W-1:0]     rd_data;

  assign accept   = start && !busy;
  assign is_full  = (count_r == FULL_CNT);
  assign is_empty = (count_r == '0);
  assign last_cnt = count_r - CNT_W'(1);

  // Ring index arithmetic: one compare and subtract brings a sum back in range.
  assign front_dec = (front_r == '0) ? LAST_SLOT : front_r - IDX_W'(1);
  assign front_inc = (front_r == LAST_SLOT) ? '0 : front_r + IDX_W'(1);
  assign back_sum  = SUM_W'(front_r) + SUM_W'(count_r);
  assign back_slot = (back_sum >= DEPTH_S) ? IDX_W'(back_sum - DEPTH_S) : IDX_W'(back_sum);

  // Slot read during a listing, walking front to back or back to front.
  assign list_pos  = list_bwd_r ? (last_cnt - list_idx_r) : list_idx_r;
  assign list_sum  = SUM_W'(front_r) + SUM_W'(list_pos);
  assign list_slot = (list_sum >= DEPTH_S) ? IDX_W'(list_sum - DEPTH_S) : IDX_W'(list_sum);
  assign list_last = (list_idx_r == last_cnt);

  // Command decode and sequencer.
  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    list_idx_nxt  = list_idx_r;
    list_bwd_nxt  = list_bwd_r;
    stat_vld_nxt  = 1'b0;
    stat_code_nxt = cdq_pkg::STAT_OK;
    rd_pend_nxt   = 1'b0;
    rd_last_nxt   = rd_last_r;
    wr_en         = 1'b0;
    wr_addr       = back_slot;
    rd_en         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (cdq_pkg::cmd_t'(in_cmd)) inside
            cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_BACK: begin
              stat_vld_nxt = 1'b1;
              if (is_full) begin
                stat_code_nxt = cdq_pkg::STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                if (cdq_pkg::cmd_t'(in_cmd) == cdq_pkg::CMD_PUSH_FRONT) begin
                  front_nxt = front_dec;
                  wr_addr   = front_dec;
                end
              end
            end
            cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_BACK: begin
              stat_vld_nxt = 1'b1;
              if (is_empty) begin
                stat_code_nxt = cdq_pkg::STAT_EMPTY;
              end else begin
                count_nxt = last_cnt;
                if (cdq_pkg::cmd_t'(in_cmd) == cdq_pkg::CMD_POP_FRONT) begin
                  front_nxt = front_inc;
                end
              end
            end
            cdq_pkg::CMD_LIST_FWD, cdq_pkg::CMD_LIST_BWD: begin
              if (is_empty) begin
                stat_vld_nxt  = 1'b1;
                stat_code_nxt = cdq_pkg::STAT_EMPTY;
              end else begin
                state_nxt    = ST_LIST;
                list_idx_nxt = '0;
                list_bwd_nxt = (cdq_pkg::cmd_t'(in_cmd) == cdq_pkg::CMD_LIST_BWD);
              end
            end
            default: begin
              // Unused command codes are taken and give no result.
            end
          endcase
        end
      end
      ST_LIST: begin
        rd_en        = 1'b1;
        rd_pend_nxt  = 1'b1;
        rd_last_nxt  = list_last;
        list_idx_nxt = list_idx_r + CNT_W'(1);
        if (list_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      front_r    <= '0;
      count_r    <= '0;
      stat_vld_r <= 1'b0;
      rd_pend_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      front_r    <= front_nxt;
      count_r    <= count_nxt;
      stat_vld_r <= stat_vld_nxt;
      rd_pend_r  <= rd_pend_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    list_idx_r  <= list_idx_nxt;
    list_bwd_r  <= list_bwd_nxt;
    stat_code_r <= stat_code_nxt;
    rd_last_r   <= rd_last_nxt;
  end

  // Slot store.
  cdq_ram #(
    .WIDTH (cdq_pkg::VALUE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_item_value),
    .rd_en   (rd_en),
    .rd_addr (list_slot),
    .rd_data (rd_data)
  );

  // Result port: either a status item or a listed value from the RAM.
  assign busy        = (state_r == ST_LIST);
  assign out_valid   = stat_vld_r || rd_pend_r;
  assign out_value   = rd_pend_r ? rd_data : '0;
  assign out_status  = rd_pend_r ? cdq_pkg::STAT_OK : stat_code_r;
  assign out_is_last = rd_pend_r ? rd_last_r : 1'b1;

  // The element count never exceeds the ring size.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("Element count exceeds queue depth.");

  // The front index always names a real slot.
  a_front_range: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= LAST_SLOT)
    else $error("Front index out of range.");

  // A status item and a listed value never compete for the result port.
  a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat_vld_r && rd_pend_r))
    else $error("Status and list results collide.");

  // A listing only runs over a non-empty queue.
  a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !is_empty)
    else $error("Listing in progress on an empty queue.");

  // Each listing read yields a result on the next cycle.
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid)
    else $error("Listing read gave no result.");

endmodule

`default_nettype wire

// File: tb/tb_circular_deque_engine.sv
// Self-checking testbench for the circular deque engine: directed and random command items.
`timescale 1ns / 100ps

module tb_circular_deque_engine;

  localparam int unsigned DEPTH        = cdq_pkg::QUEUE_DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 150;
  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned DRAIN_WAIT   = 40;

  // Command codes that the block leaves unused.
  localparam logic [cdq_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [cdq_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  // One result item as the block should present it.
  typedef struct {
    logic signed [cdq_pkg::VALUE_W-1:0] value;
    logic [cdq_pkg::STATUS_W-1:0]       status;
    logic                               last;
  } deque_result_t;

  // Bias of the random command mix.
  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} stim_mode_t;

  // Shadow deque: tracks the ring contents and queues the results each item causes.
  class deque_scoreboard;
    logic [cdq_pkg::VALUE_W-1:0] slot_mem [DEPTH];
    int unsigned                 front_slot;
    int unsigned                 held;
    deque_result_t               pending[$];
    int unsigned                 errors;

    function new();
      front_slot = 0;
      held       = 0;
      errors     = 0;
    endfunction

    function void expect_result(logic [cdq_pkg::VALUE_W-1:0] value,
                                logic [cdq_pkg::STATUS_W-1:0] status, logic last);
      deque_result_t r;
      r.value  = value;
      r.status = status;
      r.last   = last;
      pending.push_back(r);
    endfunction

    // Apply one accepted command item and work out the results it causes.
    function void take_command(logic [cdq_pkg::CMD_W-1:0] cmd,
                               logic [cdq_pkg::VALUE_W-1:0] value);
      int unsigned pos;
      case (cmd) inside
        cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_BACK: begin
          if (held >= DEPTH) begin
            expect_result('0, cdq_pkg::STAT_FULL, 1'b1);
          end else begin
            if (cmd == cdq_pkg::CMD_PUSH_FRONT) begin
              front_slot = (front_slot + DEPTH - 1) % DEPTH;
              slot_mem[front_slot] = value;
            end else begin
              slot_mem[(front_slot + held) % DEPTH] = value;
            end
            held++;
            expect_result('0, cdq_pkg::STAT_OK, 1'b1);
          end
        end
        cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_BACK: begin
          if (held == 0) begin
            expect_result('0, cdq_pkg::STAT_EMPTY, 1'b1);
          end else begin
            if (cmd == cdq_pkg::CMD_POP_FRONT) front_slot = (front_slot + 1) % DEPTH;
            held--;
            expect_result('0, cdq_pkg::STAT_OK, 1'b1);
          end
        end
        cdq_pkg::CMD_LIST_FWD, cdq_pkg::CMD_LIST_BWD: begin
          if (held == 0) begin
            expect_result('0, cdq_pkg::STAT_EMPTY, 1'b1);
          end else begin
            for (int unsigned i = 0; i < held; i++) begin
              pos = (cmd == cdq_pkg::CMD_LIST_FWD) ? i : held - 1 - i;
              expect_result(slot_mem[(front_slot + pos) % DEPTH], cdq_pkg::STAT_OK,
                            i + 1 == held);
            end
          end
        end
        default: ;  // unused codes are ignored by the block
      endcase
    endfunction

    // Compare one result item with the oldest expectation, field by field.
    function void check_result(logic signed [cdq_pkg::VALUE_W-1:0] value,
                               logic [cdq_pkg::STATUS_W-1:0] status, logic last);
      deque_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result: value %0d status %0d last %0d",
                 $time, value, status, last);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (value !== exp_r.value) begin
        $display("%0t: out_value mismatch: expected %0d actual %0d", $time, exp_r.value, value);
        errors++;
      end
      if (status !== exp_r.status) begin
        $display("%0t: out_status mismatch: expected %0d actual %0d",
                 $time, exp_r.status, status);
        errors++;
      end
      if (last !== exp_r.last) begin
        $display("%0t: out_is_last mismatch: expected %0d actual %0d", $time, exp_r.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               start = 1'b0;
  logic                               busy;
  logic [cdq_pkg::CMD_W-1:0]          in_cmd = cdq_pkg::CMD_PUSH_FRONT;
  logic signed [cdq_pkg::VALUE_W-1:0] in_item_value = '0;
  logic                               out_valid;
  logic signed [cdq_pkg::VALUE_W-1:0] out_value;
  logic [cdq_pkg::STATUS_W-1:0]       out_status;
  logic                               out_is_last;

  deque_scoreboard sb;
  int unsigned     cycle_count = 0;

  circular_deque_engine #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_cmd(in_cmd),
    .in_item_value(in_item_value),
    .out_valid(out_valid),
    .out_value(out_value),
    .out_status(out_status),
    .out_is_last(out_is_last)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog on a stuck handshake or a lost result.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Results are checked at the edge that ends their one-cycle strobe.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_result(out_value, out_status, out_is_last);
  end

  // Values weighted towards the extremes of the signed range.
  function automatic logic [cdq_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Command choice: fill and drain phases push the deque to its limits.
  function automatic logic [cdq_pkg::CMD_W-1:0] pick_command(stim_mode_t mode,
                                                             int unsigned held);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) return $urandom_range(1) ? CMD_SPARE_LO : CMD_SPARE_HI;
    if (roll < 6 || (held == DEPTH && roll < 30))
      return $urandom_range(1) ? cdq_pkg::CMD_LIST_FWD : cdq_pkg::CMD_LIST_BWD;
    case (mode)
      MODE_FILL:  roll = (roll < 85) ? 0 : 1;
      MODE_DRAIN: roll = (roll < 85) ? 1 : 0;
      default:    roll = (roll < 50) ? 0 : 1;
    endcase
    if (roll == 0) return $urandom_range(1) ? cdq_pkg::CMD_PUSH_FRONT : cdq_pkg::CMD_PUSH_BACK;
    return $urandom_range(1) ? cdq_pkg::CMD_POP_FRONT : cdq_pkg::CMD_POP_BACK;
  endfunction

  // Offer one command item, optionally after a random idle gap, and wait for acceptance.
  task automatic send_item(logic [cdq_pkg::CMD_W-1:0] cmd, logic [cdq_pkg::VALUE_W-1:0] value,
                           bit may_idle);
    if (may_idle && $urandom_range(99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start         <= 1'b1;
    in_cmd        <= cmd;
    in_item_value <= value;
    do @(posedge clk); while (busy !== 1'b0);
    sb.take_command(cmd, value);
  endtask

  // Hold the sender off until every outstanding result has arrived.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  initial begin
    stim_mode_t                mode;
    int unsigned               edge_hits;
    int unsigned               mixed_left;
    logic [cdq_pkg::CMD_W-1:0] cmd;

    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty cases, unused codes, extreme values, wrap at the front, listings.
    send_item(cdq_pkg::CMD_POP_FRONT, '0, 1'b0);
    send_item(cdq_pkg::CMD_POP_BACK, '0, 1'b0);
    send_item(cdq_pkg::CMD_LIST_FWD, '0, 1'b0);
    send_item(cdq_pkg::CMD_LIST_BWD, '0, 1'b0);
    send_item(CMD_SPARE_LO, 32'h1234_5678, 1'b0);
    send_item(CMD_SPARE_HI, '1, 1'b0);
    send_item(cdq_pkg::CMD_PUSH_BACK, 32'h8000_0000, 1'b0);
    send_item(cdq_pkg::CMD_PUSH_FRONT, 32'h7fff_ffff, 1'b0);
    send_item(cdq_pkg::CMD_PUSH_BACK, '0, 1'b0);
    send_item(cdq_pkg::CMD_PUSH_FRONT, '1, 1'b0);
    send_item(cdq_pkg::CMD_PUSH_BACK, 32'h5555_5555, 1'b0);
    send_item(cdq_pkg::CMD_PUSH_FRONT, 32'haaaa_aaaa, 1'b0);
    send_item(cdq_pkg::CMD_LIST_FWD, '0, 1'b0);
    send_item(cdq_pkg::CMD_LIST_BWD, '0, 1'b0);
    send_item(cdq_pkg::CMD_POP_FRONT, '0, 1'b0);
    send_item(cdq_pkg::CMD_POP_BACK, '0, 1'b0);
    send_item(cdq_pkg::CMD_LIST_FWD, '0, 1'b0);
    send_item(cdq_pkg::CMD_POP_FRONT, '0, 1'b0);
    send_item(cdq_pkg::CMD_POP_BACK, '0, 1'b0);
    send_item(cdq_pkg::CMD_POP_BACK, '0, 1'b0);
    send_item(cdq_pkg::CMD_POP_FRONT, '0, 1'b0);
    send_item(cdq_pkg::CMD_POP_FRONT, '0, 1'b0);
    send_item(cdq_pkg::CMD_LIST_BWD, '0, 1'b0);
    wait_drained();

    // Random: alternate fill, drain and mixed phases so that full and empty recur.
    mode       = MODE_FILL;
    edge_hits  = 0;
    mixed_left = 0;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 100) wait_drained();
      cmd = pick_command(mode, sb.held);
      send_item(cmd, pick_value(), !(n >= 60 && n < 120));
      case (mode)
        MODE_FILL: begin
          if (sb.held == DEPTH) edge_hits++;
          if (edge_hits >= 4) begin
            mode      = MODE_DRAIN;
            edge_hits = 0;
          end
        end
        MODE_DRAIN: begin
          if (sb.held == 0) edge_hits++;
          if (edge_hits >= 2) begin
            mode       = MODE_MIXED;
            edge_hits  = 0;
            mixed_left = $urandom_range(10, 25);
          end
        end
        default: begin
          mixed_left--;
          if (mixed_left == 0) mode = MODE_FILL;
        end
      endcase
    end

    // Let every result come out, then allow a margin for stray strobes.
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
